### rtl/core/gvne_pkg.sv
// Shared types, codes and helpers for the grid vertex normal engine.
`default_nettype none
package gvne_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;
    localparam int CFG_W        = 7;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_RANGE = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic signed [31:0] z_coord;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               status;
    } t_out_item;

    typedef logic signed [63:0] t_c64;
    typedef t_c64 [2:0]         t_vec64;
    typedef logic signed [31:0] t_c32;
    typedef t_c32 [2:0]         t_vec32;
    typedef logic signed [15:0] t_c16;
    typedef t_c16 [2:0]         t_vec16;

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int top);
        logic [CFG_W-1:0] res;
        if (v < CFG_W'(2)) begin
            res = CFG_W'(2);
        end else if (32'(v) > 32'(top)) begin
            res = CFG_W'(top);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### rtl/core/gvne_norm.sv
// Multi-cycle vector normaliser: length scan, sum of squares, square root, division.
`default_nettype none
module gvne_norm (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  gvne_pkg::t_vec64     i_vec,
    output logic                 o_done,
    output gvne_pkg::t_vec16     o_vec
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LEN   = 3'd1;
    localparam logic [2:0] S_SCALE = 3'd2;
    localparam logic [2:0] S_SQ    = 3'd3;
    localparam logic [2:0] S_SQRT  = 3'd4;
    localparam logic [2:0] S_DINIT = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]   r_state;
    logic [63:0]  r_m [3];
    logic [2:0]   r_neg;
    logic [63:0]  r_t;
    logic [6:0]   r_len;
    logic [1:0]   r_k;
    logic [61:0]  r_sum;
    logic [63:0]  r_v;
    logic [63:0]  r_res;
    logic [63:0]  r_bit;
    logic [4:0]   r_cnt;
    logic [14:0]  r_low;
    logic [30:0]  r_rem;
    logic [3:0]   r_dc;
    logic [14:0]  r_q;
    gvne_pkg::t_vec16 r_out;

    logic [63:0] mag [3];
    logic [59:0] sq;
    logic [63:0] sqt;
    logic [44:0] num;
    logic [31:0] trial;
    logic        qbit;
    logic [14:0] qfull;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag[k] = i_vec[k][63] ? 64'(-$signed(i_vec[k])) : 64'(i_vec[k]);
        end
        sq    = r_m[r_k][29:0] * r_m[r_k][29:0];
        sqt   = r_res + r_bit;
        num   = (45'(r_m[r_k][29:0]) << 14) + 45'(r_res[31:1]);
        trial = {r_rem, r_low[14]};
        qbit  = trial >= r_res[31:0];
        qfull = {r_q[13:0], qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        for (int k = 0; k < 3; k++) begin
                            r_m[k]   <= mag[k];
                            r_neg[k] <= i_vec[k][63];
                        end
                        r_t     <= mag[0] | mag[1] | mag[2];
                        r_len   <= '0;
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    // bit length of the OR equals that of the largest magnitude
                    if (r_t != '0) begin
                        r_t   <= r_t >> 1;
                        r_len <= r_len + 7'd1;
                    end else if (r_len == '0) begin
                        r_out   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    for (int k = 0; k < 3; k++) begin
                        if (r_len > 7'd30) begin
                            r_m[k] <= r_m[k] >> (r_len - 7'd30);
                        end else begin
                            r_m[k] <= r_m[k] << (7'd30 - r_len);
                        end
                    end
                    r_sum   <= '0;
                    r_k     <= '0;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_sum <= r_sum + 62'(sq);
                    if (r_k == 2'd2) begin
                        r_v     <= 64'(r_sum) + 64'(sq);
                        r_res   <= '0;
                        r_bit   <= 64'd1 << 62;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                S_SQRT: begin
                    if (r_v >= sqt) begin
                        r_v   <= r_v - sqt;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_k     <= '0;
                        r_state <= S_DINIT;
                    end
                end
                S_DINIT: begin
                    r_rem   <= 31'(num[44:15]);
                    r_low   <= num[14:0];
                    r_dc    <= 4'd14;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (qbit) begin
                        r_rem <= 31'(trial - r_res[31:0]);
                    end else begin
                        r_rem <= trial[30:0];
                    end
                    r_low <= r_low << 1;
                    r_q   <= qfull;
                    r_dc  <= r_dc - 4'd1;
                    if (r_dc == '0) begin
                        r_out[r_k] <= r_neg[r_k] ? -$signed(16'(qfull)) : $signed(16'(qfull));
                        if (r_k == 2'd2) begin
                            r_state <= S_DONE;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_DINIT;
                        end
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_state == S_DONE;
    assign o_vec  = r_out;

endmodule
`default_nettype wire

### rtl/core/grid_vertex_normal_engine.sv
// Top level: point memory, triangle sequencer, cross product and vertex normal sum.
//
//  channel   direction  handshake                     payload
//  in        sink       i_in_valid / o_in_ready       i_in_item  (gvne_pkg::t_in_item)
//  out       source     o_out_valid / i_out_ready     o_out_item (gvne_pkg::t_out_item)
//  cfg       sink       i_cfg_we                      i_cfg_idx, i_cfg_wdata
//
// One transaction at a time. Writes and out-of-grid items show their result the cycle after
// accept. A read takes per touching triangle a check, three memory reads (a read and a capture
// state each), the cross product as an edge step and six multiply-accumulate steps on one
// 32x32 multiplier, and one pass of the normaliser (bit-serial length scan up to 64, 32 root
// steps, 3 x (1 load + 15 division steps)); one more normaliser pass for the sum.
// Reset sets the grid to full size; the point memory is not cleared.
// A stalled result holds in the output register; no new transaction is taken meanwhile.
`default_nettype none
module grid_vertex_normal_engine #(
    parameter int MAX_ROWS = gvne_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gvne_pkg::DEF_MAX_COLS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  gvne_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output gvne_pkg::t_out_item              o_out_item,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_idx,
    input  wire logic [gvne_pkg::CFG_W-1:0]  i_cfg_wdata
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [gvne_pkg::CFG_W-1:0] RST_ROWS =
        gvne_pkg::clamp_dim(gvne_pkg::CFG_W'(MAX_ROWS), MAX_ROWS);
    localparam logic [gvne_pkg::CFG_W-1:0] RST_COLS =
        gvne_pkg::clamp_dim(gvne_pkg::CFG_W'(MAX_COLS), MAX_COLS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TCHK  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_CAP   = 4'd3;
    localparam logic [3:0] S_EDGE  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_ACC   = 4'd6;
    localparam logic [3:0] S_NWAIT = 4'd7;
    localparam logic [3:0] S_FWAIT = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    localparam logic [1:0] PT_P = 2'd0;
    localparam logic [1:0] PT_U = 2'd1;
    localparam logic [1:0] PT_V = 2'd2;

    // {row step, col step, second triangle} of the six triangles around a vertex
    localparam logic [2:0] TRI_TAB [6] = '{3'b000, 3'b001, 3'b110, 3'b111, 3'b100, 3'b011};
    // cross product operand selects: n0 = u1v2-u2v1, n1 = u2v0-u0v2, n2 = u0v1-u1v0
    localparam logic [1:0] MUL_A [6] = '{2'd1, 2'd2, 2'd2, 2'd0, 2'd0, 2'd1};
    localparam logic [1:0] MUL_B [6] = '{2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0};

    logic [95:0] mem [DEPTH];
    logic [95:0] r_rdata;

    logic [3:0]                    r_state;
    logic [gvne_pkg::CFG_W-1:0]    r_rows;
    logic [gvne_pkg::CFG_W-1:0]    r_cols;
    gvne_pkg::t_in_item            r_item;
    gvne_pkg::t_out_item           r_out;
    logic [2:0]                    r_tri;
    logic [1:0]                    r_pt;
    logic [2:0]                    r_k;
    gvne_pkg::t_vec32              r_p;
    gvne_pkg::t_vec32              r_u;
    gvne_pkg::t_vec32              r_v;
    gvne_pkg::t_vec32              r_eu;
    gvne_pkg::t_vec32              r_ev;
    gvne_pkg::t_vec64              r_n;
    logic signed [63:0]            r_prod;
    logic signed [17:0]            r_acc [3];
    logic                          r_nstart;

    logic                 in_acc;
    logic                 oor;
    logic                 mem_we;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic [2:0]           tri_sel;
    logic [6:0]           qi;
    logic [6:0]           qj;
    logic                 qok;
    logic [6:0]           pr;
    logic [6:0]           pc;
    gvne_pkg::t_vec32     rd_pt;
    gvne_pkg::t_vec64     norm_vec;
    gvne_pkg::t_vec16     norm_res;
    logic                 norm_done;
    logic                 n_nstart;

    assign o_in_ready = r_state == S_IDLE;
    assign in_acc     = i_in_valid && o_in_ready;
    assign oor        = ({1'b0, i_in_item.row} >= r_rows) || ({1'b0, i_in_item.col} >= r_cols);
    assign mem_we     = in_acc && !oor && (i_in_item.opcode == gvne_pkg::OP_WRITE);
    assign wr_addr    = AW'(32'(i_in_item.row) * 32'(MAX_COLS) + 32'(i_in_item.col));

    // start the normaliser after the last product of a triangle or for the final sum
    assign n_nstart = ((r_state == S_TCHK) && !qok && (r_tri == 3'd5))
                   || ((r_state == S_ACC) && (r_k == 3'd5))
                   || ((r_state == S_NWAIT) && norm_done && (r_tri == 3'd5));

    always_comb begin
        tri_sel = TRI_TAB[r_tri];
        qi      = 7'(r_item.row) + 7'(tri_sel[2]);
        qj      = 7'(r_item.col) + 7'(tri_sel[1]);
        qok     = (qi != '0) && (qj != '0) && (qi < r_rows) && (qj < r_cols);
        // U sits one row up; V one row up only in the first triangle
        pr      = qi - 7'((r_pt == PT_U) || ((r_pt == PT_V) && !tri_sel[0]));
        pc      = qj - 7'(((r_pt == PT_U) && tri_sel[0]) || (r_pt == PT_V));
        rd_addr = AW'(32'(pr) * 32'(MAX_COLS) + 32'(pc));
        rd_pt   = {r_rdata[31:0], r_rdata[63:32], r_rdata[95:64]};
        if (r_state == S_FWAIT) begin
            for (int k = 0; k < 3; k++) begin
                norm_vec[k] = 64'(r_acc[k]);
            end
        end else begin
            norm_vec = r_n;
        end
    end

    // point memory, x in the top word
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= {i_in_item.x_coord, i_in_item.y_coord, i_in_item.z_coord};
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= RST_ROWS;
            r_cols <= RST_COLS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gvne_pkg::CFG_ROWS: r_rows <= gvne_pkg::clamp_dim(i_cfg_wdata, MAX_ROWS);
                gvne_pkg::CFG_COLS: r_cols <= gvne_pkg::clamp_dim(i_cfg_wdata, MAX_COLS);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_nstart <= 1'b0;
        end else begin
            r_nstart <= n_nstart;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_item          <= i_in_item;
                        r_out.normal_x  <= '0;
                        r_out.normal_y  <= '0;
                        r_out.normal_z  <= '0;
                        r_out.status    <= oor ? gvne_pkg::ST_RANGE : gvne_pkg::ST_OK;
                        if (oor) begin
                            r_state <= S_OUT;
                        end else if (i_in_item.opcode == gvne_pkg::OP_WRITE) begin
                            r_state <= S_OUT;
                        end else begin
                            r_tri <= '0;
                            for (int k = 0; k < 3; k++) begin
                                r_acc[k] <= '0;
                            end
                            r_state <= S_TCHK;
                        end
                    end
                end
                S_TCHK: begin
                    if (qok) begin
                        r_pt    <= PT_P;
                        r_state <= S_RD;
                    end else if (r_tri == 3'd5) begin
                        r_state <= S_FWAIT;
                    end else begin
                        r_tri <= r_tri + 3'd1;
                    end
                end
                S_RD: begin
                    r_state <= S_CAP;
                end
                S_CAP: begin
                    case (r_pt)
                        PT_P:    r_p <= rd_pt;
                        PT_U:    r_u <= rd_pt;
                        default: r_v <= rd_pt;
                    endcase
                    if (r_pt == PT_V) begin
                        r_state <= S_EDGE;
                    end else begin
                        r_pt    <= r_pt + 2'd1;
                        r_state <= S_RD;
                    end
                end
                S_EDGE: begin
                    // halve with floor: drop the low bit of the 33-bit difference
                    for (int k = 0; k < 3; k++) begin
                        r_eu[k] <= 32'((33'(r_u[k]) - 33'(r_p[k])) >>> 1);
                        r_ev[k] <= 32'((33'(r_v[k]) - 33'(r_p[k])) >>> 1);
                    end
                    r_k     <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= $signed(r_eu[MUL_A[r_k]]) * $signed(r_ev[MUL_B[r_k]]);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (!r_k[0]) begin
                        r_n[r_k[2:1]] <= r_prod;
                    end else begin
                        r_n[r_k[2:1]] <= $signed(r_n[r_k[2:1]]) - r_prod;
                    end
                    if (r_k == 3'd5) begin
                        r_state <= S_NWAIT;
                    end else begin
                        r_k     <= r_k + 3'd1;
                        r_state <= S_MUL;
                    end
                end
                S_NWAIT: begin
                    if (norm_done) begin
                        for (int k = 0; k < 3; k++) begin
                            r_acc[k] <= r_acc[k] + 18'($signed(norm_res[k]));
                        end
                        if (r_tri == 3'd5) begin
                            r_state <= S_FWAIT;
                        end else begin
                            r_tri   <= r_tri + 3'd1;
                            r_state <= S_TCHK;
                        end
                    end
                end
                S_FWAIT: begin
                    if (norm_done) begin
                        r_out.normal_x <= norm_res[0];
                        r_out.normal_y <= norm_res[1];
                        r_out.normal_z <= norm_res[2];
                        r_out.status   <= gvne_pkg::ST_OK;
                        r_state        <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    gvne_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_nstart),
        .i_vec   (norm_vec),
        .o_done  (norm_done),
        .o_vec   (norm_res)
    );

    assign o_out_valid = r_state == S_OUT;
    assign o_out_item  = r_out;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input ready while a result is pending");

    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> o_out_valid && (o_out_item.status == gvne_pkg::ST_OK)
                   && (o_out_item.normal_x == '0) && (o_out_item.normal_z == '0))
        else $error("write transaction result wrong");

    a_range_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && oor) |=> o_out_valid && (o_out_item.status == gvne_pkg::ST_RANGE))
        else $error("out-of-grid transaction not flagged");

    a_norm_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        norm_done |-> (r_state == S_NWAIT) || (r_state == S_FWAIT))
        else $error("normaliser finished with nobody waiting");

endmodule
`default_nettype wire

### verif/tb_grid_vertex_normal_engine.sv
// Self-checking testbench for the grid vertex normal engine.
`timescale 1ns / 1ps
`default_nettype none
module tb_grid_vertex_normal_engine;

    localparam int NR = gvne_pkg::DEF_MAX_ROWS;
    localparam int NC = gvne_pkg::DEF_MAX_COLS;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    gvne_pkg::t_in_item         in_item = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    gvne_pkg::t_out_item        out_item;
    logic                       cfg_we = 1'b0;
    logic                       cfg_idx = gvne_pkg::CFG_ROWS;
    logic [gvne_pkg::CFG_W-1:0] cfg_wdata = '0;

    grid_vertex_normal_engine dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_item(out_item),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor state
    gvne_pkg::t_vec32     grid_pts [NR*NC];
    bit                   grid_written [NR*NC];
    int unsigned          grid_rows = NR;
    int unsigned          grid_cols = NC;
    gvne_pkg::t_out_item  pending_normals [$];
    int                   fail_count = 0;
    int                   reads_sent = 0;
    int                   writes_sent = 0;
    int                   range_errs = 0;

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic gvne_pkg::t_vec64 unit_vec(input gvne_pkg::t_vec64 c);
        logic [63:0]      m [3];
        logic [63:0]      big, sum, r, q;
        bit               neg [3];
        int               len;
        gvne_pkg::t_vec64 o;
        big = 0;
        sum = 0;
        len = 0;
        o = '0;
        for (int k = 0; k < 3; k++) begin
            neg[k] = c[k] < 0;
            m[k] = neg[k] ? -c[k] : c[k];
            if (m[k] > big) big = m[k];
        end
        while (len < 64 && (big >> len) != 0) len++;
        if (len == 0) return o;
        for (int k = 0; k < 3; k++) begin
            if (len > 30) m[k] = m[k] >> (len - 30);
            else m[k] = m[k] << (30 - len);
            sum += m[k] * m[k];
        end
        r = root64(sum);
        for (int k = 0; k < 3; k++) begin
            q = (m[k] * 64'd16384 + r / 2) / r;
            o[k] = neg[k] ? -$signed(q) : $signed(q);
        end
        return o;
    endfunction

    function automatic gvne_pkg::t_vec64 half_edge(input gvne_pkg::t_vec32 a,
                                                   input gvne_pkg::t_vec32 b);
        gvne_pkg::t_vec64 e;
        for (int k = 0; k < 3; k++) e[k] = (64'(a[k]) - 64'(b[k])) >>> 1;
        return e;
    endfunction

    function automatic gvne_pkg::t_vec64 cross3(input gvne_pkg::t_vec64 a,
                                                input gvne_pkg::t_vec64 b);
        gvne_pkg::t_vec64 n;
        n[0] = a[1]*b[2] - a[2]*b[1];
        n[1] = a[2]*b[0] - a[0]*b[2];
        n[2] = a[0]*b[1] - a[1]*b[0];
        return n;
    endfunction

    // Add the unit normal of one triangle of quad (i, j); lower == 0 selects the first.
    function automatic void add_facet(input int i, input int j, input int lower,
                                      inout gvne_pkg::t_vec64 acc);
        gvne_pkg::t_vec64 e1, e2, u;
        if (i < 1 || j < 1 || i >= grid_rows || j >= grid_cols) return;
        e2 = half_edge(grid_pts[(i-1)*NC + j-1], grid_pts[i*NC + j]);
        if (lower == 0) begin
            e1 = half_edge(grid_pts[(i-1)*NC + j], grid_pts[i*NC + j]);
            u = unit_vec(cross3(e1, e2));
        end else begin
            e1 = half_edge(grid_pts[i*NC + j-1], grid_pts[i*NC + j]);
            u = unit_vec(cross3(e2, e1));
        end
        for (int k = 0; k < 3; k++) acc[k] += u[k];
    endfunction

    function automatic gvne_pkg::t_out_item predict_normal(input gvne_pkg::t_in_item it);
        gvne_pkg::t_out_item o;
        gvne_pkg::t_vec64    acc, res;
        int                  r, c;
        r = it.row;
        c = it.col;
        o = '0;
        acc = '0;
        if (r >= grid_rows || c >= grid_cols) begin
            o.status = gvne_pkg::ST_RANGE;
        end else if (it.opcode == gvne_pkg::OP_WRITE) begin
            // element 0 holds x
            grid_pts[r*NC + c] = '{it.z_coord, it.y_coord, it.x_coord};
            grid_written[r*NC + c] = 1'b1;
        end else begin
            add_facet(r, c, 0, acc);
            add_facet(r, c, 1, acc);
            add_facet(r+1, c+1, 0, acc);
            add_facet(r+1, c+1, 1, acc);
            add_facet(r+1, c, 0, acc);
            add_facet(r, c+1, 1, acc);
            res = unit_vec(acc);
            o.normal_x = res[0][15:0];
            o.normal_y = res[1][15:0];
            o.normal_z = res[2][15:0];
            o.status = gvne_pkg::ST_OK;
        end
        return o;
    endfunction

    // True when every point in the neighbourhood that a read touches has been written.
    function automatic bit neighbours_written(input int r, input int c);
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
                if (r+dr >= 0 && c+dc >= 0 && r+dr < grid_rows && c+dc < grid_cols)
                    if (!grid_written[(r+dr)*NC + c+dc]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic send_item(input gvne_pkg::t_in_item it);
        int gap;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge clk);
        in_item = it;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_normals.push_back(predict_normal(it));
        if (it.opcode == gvne_pkg::OP_READ) reads_sent++;
        else writes_sent++;
        if (it.row >= grid_rows || it.col >= grid_cols) range_errs++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_pt(input int r, input int c, input gvne_pkg::t_c32 x,
                            input gvne_pkg::t_c32 y, input gvne_pkg::t_c32 z);
        gvne_pkg::t_in_item it;
        it = '{gvne_pkg::OP_WRITE, 6'(r), 6'(c), x, y, z};
        send_item(it);
    endtask

    task automatic read_pt(input int r, input int c);
        gvne_pkg::t_in_item it;
        it = '{gvne_pkg::OP_READ, 6'(r), 6'(c), $urandom, $urandom, $urandom};
        send_item(it);
    endtask

    task automatic drain();
        while (pending_normals.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_grid(input logic [gvne_pkg::CFG_W-1:0] rows,
                            input logic [gvne_pkg::CFG_W-1:0] cols);
        drain();
        cfg_we <= 1'b1;
        cfg_idx <= gvne_pkg::CFG_ROWS;
        cfg_wdata <= rows;
        @(negedge clk);
        cfg_idx <= gvne_pkg::CFG_COLS;
        cfg_wdata <= cols;
        @(negedge clk);
        cfg_we <= 1'b0;
        grid_rows = rows < 2 ? 2 : (rows > NR ? NR : rows);
        grid_cols = cols < 2 ? 2 : (cols > NC ? NC : cols);
    endtask

    function automatic gvne_pkg::t_c32 rand_coord(input int mode);
        case (mode)
            0: return $signed($urandom);
            1: return $signed($urandom_range(0, 8)) <<< 16;
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 255)) - 128;
        endcase
    endfunction

    task automatic fill_grid(input int mode);
        for (int r = 0; r < grid_rows; r++)
            for (int c = 0; c < grid_cols; c++)
                write_pt(r, c, rand_coord(mode), rand_coord(mode), rand_coord(mode));
    endtask

    // Extremes, flat and degenerate patches, out-of-grid indices.
    task automatic test_directed();
        set_grid(7'd2, 7'd3);
        write_pt(0, 0, 0, 0, 0);
        write_pt(0, 1, 32'sh10000, 0, 0);
        write_pt(0, 2, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        write_pt(1, 0, 0, 32'sh10000, 0);
        write_pt(1, 1, 32'sh10000, 32'sh10000, 0);
        write_pt(1, 2, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        read_pt(0, 0);
        read_pt(1, 1);
        read_pt(0, 2);
        read_pt(1, 2);
        write_pt(2, 0, 1, 1, 1);
        read_pt(63, 63);
        write_pt(0, 63, 1, 1, 1);
        // degenerate patch: all points equal, sum cancels to zero
        for (int r = 0; r < 2; r++)
            for (int c = 0; c < 3; c++)
                write_pt(r, c, 32'sh12345, -5, 7);
        read_pt(0, 1);
        read_pt(1, 0);
        set_grid(7'd0, 7'd127);
        read_pt(1, 1);
        read_pt(2, 2);
    endtask

    task automatic test_random_grids();
        int rows, cols, n;
        for (int phase = 0; phase < 24; phase++) begin
            if (phase == 5) begin
                rows = 64; cols = 64;
            end else if (phase % 6 == 1) begin
                rows = $urandom_range(2, 64); cols = 2;
            end else begin
                rows = $urandom_range(2, 8); cols = $urandom_range(2, 8);
            end
            set_grid(7'(rows), 7'(cols));
            if (phase == 5) begin
                for (int k = 0; k < 30; k++)
                    write_pt($urandom_range(0, 63), $urandom_range(0, 63),
                             rand_coord(0), rand_coord(0), rand_coord(0));
            end else begin
                fill_grid(phase % 4);
            end
            n = (phase == 5) ? 10 : 30;
            for (int k = 0; k < n; k++) begin
                gvne_pkg::t_in_item it;
                it.opcode = $urandom_range(0, 4) != 0 ? gvne_pkg::OP_READ
                                                      : gvne_pkg::OP_WRITE;
                it.row = $urandom_range(0, 9) == 0 ? $urandom_range(0, 63)
                                                   : $urandom_range(0, grid_rows - 1);
                it.col = $urandom_range(0, 9) == 0 ? $urandom_range(0, 63)
                                                   : $urandom_range(0, grid_cols - 1);
                it.x_coord = rand_coord(phase % 4);
                it.y_coord = rand_coord(phase % 4);
                it.z_coord = rand_coord(phase % 4);
                if (it.opcode == gvne_pkg::OP_READ && it.row < grid_rows
                    && it.col < grid_cols && !neighbours_written(it.row, it.col))
                    it.opcode = gvne_pkg::OP_WRITE;
                send_item(it);
            end
            if (phase == 9) drain();
        end
    endtask

    // Shrink the grid under stored points, then reads only see inner triangles.
    task automatic test_shrink();
        set_grid(7'd6, 7'd6);
        fill_grid(0);
        set_grid(7'd3, 7'd4);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 4; c++) read_pt(r, c);
        read_pt(3, 0);
        set_grid(7'd64, 7'd64);
    endtask

    // Drive ready with random stalls and check each result in order.
    initial begin
        gvne_pkg::t_out_item want;
        int                  stall;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            @(negedge clk);
            stall = $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if (pending_normals.size() == 0) begin
                $error("result with no transaction outstanding: %p", out_item);
                fail_count++;
            end else begin
                want = pending_normals.pop_front();
                if (out_item.normal_x !== want.normal_x) begin
                    $error("normal_x exp %0d got %0d", want.normal_x, out_item.normal_x);
                    fail_count++;
                end
                if (out_item.normal_y !== want.normal_y) begin
                    $error("normal_y exp %0d got %0d", want.normal_y, out_item.normal_y);
                    fail_count++;
                end
                if (out_item.normal_z !== want.normal_z) begin
                    $error("normal_z exp %0d got %0d", want.normal_z, out_item.normal_z);
                    fail_count++;
                end
                if (out_item.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, out_item.status);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #60ms;
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_shrink();
        test_random_grids();
        drain();
        repeat (50) @(negedge clk);
        if (pending_normals.size() != 0) begin
            $error("%0d expected results never arrived", pending_normals.size());
            fail_count++;
        end
        $display("Sent %0d point writes and %0d normal reads, %0d outside the grid,",
                 writes_sent, reads_sent, range_errs);
        $display("across grid sizes from 2x2 up to 64x64.");
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
